@@ src/xbrs_pkg.sv @@
// ----------------------------------------------------------------------------
// xbrs_pkg: shared types and constants of the bounded random source
// Mode codes, splitmix64 constants, the xorshift step and divider sizing.
// ----------------------------------------------------------------------------
package xbrs_pkg;

  typedef logic [63:0] word_t;
  typedef logic [2:0]  mode_t;
  typedef logic [3:0][1:0] perm_t;

  localparam mode_t ModeReseed  = 3'd0;
  localparam mode_t ModeRaw     = 3'd1;
  localparam mode_t ModeBounded = 3'd2;
  localparam mode_t ModeFrac    = 3'd3;
  localparam mode_t ModeShuffle = 3'd4;

  localparam word_t GoldenInc = 64'h9e37_79b9_7f4a_7c15;
  localparam word_t MixMulA   = 64'hbf58_476d_1ce4_e5b9;
  localparam word_t MixMulB   = 64'h94d0_49bb_1331_11eb;
  localparam word_t GenReset  = 64'he220_a839_7b1d_cdaf;

  localparam int unsigned RemSteps = 33;
  localparam int unsigned RemCntW  = $clog2(RemSteps);

  function automatic word_t xs_step(input word_t s);
    word_t t;
    t = s ^ (s << 13);
    t = t ^ (t >> 7);
    t = t ^ (t << 17);
    return t;
  endfunction

endpackage

@@ src/xorshift_bounded_random_source_top.sv @@
// Reseed runs the splitmix64 mix through the shared multiplier; a bounded integer
// draws again after each rejected draw; a shuffle takes three bounded draws.
// A bound of 0 or 1 and the unused modes return zero without a draw.
// One item at a time; the next transfer can be taken while a result waits.
// Reset loads the generator with the splitmix64 mix of seed zero.
// ----------------------------------------------------------------------------
// xorshift_bounded_random_source_top: xorshift64 random source
// Sequencer around a shared multiplier and remainder unit.
// ----------------------------------------------------------------------------
module xorshift_bounded_random_source_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  xbrs_pkg::mode_t  mode_i,
  input  xbrs_pkg::word_t  seed_value_i,
  input  logic [31:0]      bound_i,
  output logic             valid_o,
  input  logic             stall_i,
  output xbrs_pkg::word_t  value_o
);
  import xbrs_pkg::*;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SMixA  = 4'd1;
  localparam logic [3:0] SMixAW = 4'd2;
  localparam logic [3:0] SMixB  = 4'd3;
  localparam logic [3:0] SMixBW = 4'd4;
  localparam logic [3:0] SCut   = 4'd5;
  localparam logic [3:0] SCutW  = 4'd6;
  localparam logic [3:0] SDraw  = 4'd7;
  localparam logic [3:0] SModW  = 4'd8;
  localparam logic [3:0] SDone  = 4'd9;

  logic [3:0]  state_q, state_d;
  word_t       gen_q, gen_d;
  word_t       z_q, z_d;
  word_t       res_q, res_d;
  logic [31:0] lim_q, lim_d;
  logic [32:0] cut_q, cut_d;
  logic [1:0]  idx_q, idx_d;
  logic        shuf_q, shuf_d;
  perm_t       perm_q, perm_d;
  logic        out_valid_q, out_valid_d;
  word_t       out_value_q, out_value_d;

  word_t       gen_next;
  perm_t       perm_sw;
  logic [1:0]  pick;
  logic        mul_start, mul_done;
  word_t       mul_a, mul_b, mul_prod;
  logic        rem_start, rem_done;
  logic [32:0] rem_dvd;
  logic [31:0] rem_out;

  xbrs_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (mul_a),
    .b_i       (mul_b),
    .done_o    (mul_done),
    .product_o (mul_prod)
  );

  xbrs_rem u_rem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (rem_start),
    .dividend_i  (rem_dvd),
    .divisor_i   (lim_q),
    .done_o      (rem_done),
    .remainder_o (rem_out)
  );

  always_comb begin
    state_d     = state_q;
    gen_d       = gen_q;
    z_d         = z_q;
    res_d       = res_q;
    lim_d       = lim_q;
    cut_d       = cut_q;
    idx_d       = idx_q;
    shuf_d      = shuf_q;
    perm_d      = perm_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    mul_start   = 1'b0;
    mul_a       = z_q ^ (z_q >> 30);
    mul_b       = MixMulA;
    rem_start   = 1'b0;
    rem_dvd     = {1'b1, 32'b0};
    gen_next    = xs_step(gen_q);
    pick        = rem_out[1:0];
    perm_sw     = perm_q;
    perm_sw[idx_q] = perm_q[pick];
    perm_sw[pick]  = perm_q[idx_q];

    if (out_valid_q && !stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      SIdle: begin
        if (valid_i) begin
          case (mode_i)
            ModeReseed: begin
              z_d     = seed_value_i + GoldenInc;
              state_d = SMixA;
            end
            ModeRaw: begin
              gen_d   = gen_next;
              res_d   = gen_next;
              state_d = SDone;
            end
            ModeFrac: begin
              gen_d   = gen_next;
              res_d   = gen_next >> 11;
              state_d = SDone;
            end
            ModeBounded: begin
              if (bound_i <= 32'd1) begin
                res_d   = '0;
                state_d = SDone;
              end else begin
                lim_d   = bound_i;
                shuf_d  = 1'b0;
                state_d = SCut;
              end
            end
            ModeShuffle: begin
              lim_d   = 32'd4;
              idx_d   = 2'd3;
              shuf_d  = 1'b1;
              perm_d  = {2'd3, 2'd2, 2'd1, 2'd0};
              state_d = SCut;
            end
            default: begin
              res_d   = '0;
              state_d = SDone;
            end
          endcase
        end
      end
      SMixA: begin
        mul_start = 1'b1;
        state_d   = SMixAW;
      end
      SMixAW: begin
        if (mul_done) begin
          z_d     = mul_prod;
          state_d = SMixB;
        end
      end
      SMixB: begin
        mul_start = 1'b1;
        mul_a     = z_q ^ (z_q >> 27);
        mul_b     = MixMulB;
        state_d   = SMixBW;
      end
      SMixBW: begin
        if (mul_done) begin
          gen_d   = mul_prod ^ (mul_prod >> 31);
          res_d   = mul_prod ^ (mul_prod >> 31);
          state_d = SDone;
        end
      end
      SCut: begin
        rem_start = 1'b1;
        state_d   = SCutW;
      end
      SCutW: begin
        if (rem_done) begin
          cut_d   = {1'b1, 32'b0} - {1'b0, rem_out};
          state_d = SDraw;
        end
      end
      SDraw: begin
        gen_d = gen_next;
        if ({1'b0, gen_next[31:0]} < cut_q) begin
          rem_start = 1'b1;
          rem_dvd   = {1'b0, gen_next[31:0]};
          state_d   = SModW;
        end
      end
      SModW: begin
        if (rem_done) begin
          if (shuf_q) begin
            perm_d = perm_sw;
            if (idx_q == 2'd1) begin
              res_d   = {56'b0, perm_sw};
              state_d = SDone;
            end else begin
              lim_d   = {30'b0, idx_q};
              idx_d   = idx_q - 2'd1;
              state_d = SCut;
            end
          end else begin
            res_d   = {32'b0, rem_out};
            state_d = SDone;
          end
        end
      end
      SDone: begin
        if (!out_valid_q || !stall_i) begin
          out_valid_d = 1'b1;
          out_value_d = res_q;
          state_d     = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      gen_q       <= GenReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gen_q       <= gen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q         <= z_d;
    res_q       <= res_d;
    lim_q       <= lim_d;
    cut_q       <= cut_d;
    idx_q       <= idx_d;
    shuf_q      <= shuf_d;
    perm_q      <= perm_d;
    out_value_q <= out_value_d;
  end

  assign stall_o = (state_q != SIdle);
  assign valid_o = out_valid_q;
  assign value_o = out_value_q;

endmodule

@@ src/xbrs_mul.sv @@
// ----------------------------------------------------------------------------
// xbrs_mul: iterative 64-bit multiplier, low half of the product
// One 32x32 multiplier forms three partial products in turn.
// ----------------------------------------------------------------------------
module xbrs_mul (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  xbrs_pkg::word_t  a_i,
  input  xbrs_pkg::word_t  b_i,
  output logic             done_o,
  output xbrs_pkg::word_t  product_o
);
  import xbrs_pkg::*;

  logic        busy_q, busy_d;
  logic [1:0]  phase_q, phase_d;
  word_t       a_q, a_d, b_q, b_d;
  word_t       prod_q, prod_d;
  word_t       acc_q, acc_d;
  logic [31:0] op_a, op_b;

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    op_a    = a_q[31:0];
    op_b    = b_q[31:0];
    case (phase_q)
      2'd1:    op_b = b_q[63:32];
      2'd2:    op_a = a_q[63:32];
      default: op_b = b_q[31:0];
    endcase
    prod_d = op_a * op_b;
    if (busy_q) begin
      phase_d = phase_q + 2'd1;
      case (phase_q)
        2'd1:    acc_d = prod_q;
        2'd2:    acc_d = acc_q + {prod_q[31:0], 32'b0};
        2'd3:    busy_d = 1'b0;
        default: acc_d = acc_q;
      endcase
    end
    if (start_i) begin
      busy_d  = 1'b1;
      phase_d = 2'd0;
      a_d     = a_i;
      b_d     = b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 2'd0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign done_o    = busy_q && (phase_q == 2'd3);
  assign product_o = acc_q + {prod_q[31:0], 32'b0};

endmodule

@@ src/xbrs_rem.sv @@
// ----------------------------------------------------------------------------
// xbrs_rem: iterative remainder unit
// Restoring division of a 33-bit dividend by a 32-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module xbrs_rem (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] remainder_o
);
  import xbrs_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [RemCntW-1:0] cnt_q, cnt_d;
  logic [32:0]        dvd_q, dvd_d;
  logic [31:0]        div_q, div_d;
  logic [31:0]        rem_q, rem_d;
  logic [32:0]        trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[32]};
    if (busy_q) begin
      dvd_d = {dvd_q[31:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = 32'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[31:0];
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = RemCntW'(RemSteps - 1);
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o      = done_q;
  assign remainder_o = rem_q;

endmodule
